// ===== design/sha256_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-256 package
// Shared types, constants and the rotate function for the SHA-256 digest block.
// ----------------------------------------------------------------------------
package sha256_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LEN,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic       put_byte;
        logic [7:0] put_value;
        logic       add_bits;
        logic       load_vars;
        logic       do_round;
        logic       add_hash;
        logic       restart;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [5:0] byte_pos;
        logic [5:0] round;
        logic [7:0] len_byte;
    } ctrl_status_t;

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

// ===== design/sha256_ctrl.sv =====
// ----------------------------------------------------------------------------
// SHA-256 controller
// Sequences byte absorption, padding, the length field, compression rounds
// and the digest output.
// ----------------------------------------------------------------------------
module sha256_ctrl (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_fire,
    input  logic [7:0]                in_byte,
    input  logic                      in_valid_byte,
    input  logic                      in_end,
    output logic                      in_ready,
    input  logic                      out_fire,
    output logic                      out_valid,
    output logic [2:0]                out_index,
    input  sha256_pkg::ctrl_status_t  status,
    output sha256_pkg::ctrl_cmd_t     cmd
);
    import sha256_pkg::*;

    state_t     state_reg, state_next;
    state_t     ret_reg, ret_next;
    logic [2:0] idx_reg, idx_next;
    logic [2:0] lcnt_reg, lcnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
            idx_reg   <= '0;
            lcnt_reg  <= '0;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            idx_reg   <= idx_next;
            lcnt_reg  <= lcnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        ret_next   = ret_reg;
        idx_next   = idx_reg;
        lcnt_next  = lcnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_fire) begin
                    cmd.put_byte  = in_valid_byte;
                    cmd.put_value = in_byte;
                    cmd.add_bits  = in_valid_byte;
                    ret_next      = in_end ? ST_PAD : ST_IDLE;
                    if (in_valid_byte && status.byte_pos == 6'd63) begin
                        cmd.load_vars = 1'b1;
                        state_next    = ST_ROUND;
                    end else begin
                        state_next = in_end ? ST_PAD : ST_IDLE;
                    end
                end
            end
            ST_PAD: begin
                cmd.put_byte  = 1'b1;
                cmd.put_value = (ret_reg == ST_PAD) ? PAD_MARK : 8'h00;
                lcnt_next     = '0;
                if (status.byte_pos == 6'd63) begin
                    cmd.load_vars = 1'b1;
                    ret_next      = ST_LEN;
                    state_next    = ST_ROUND;
                end else if (status.byte_pos == LEN_POS - 6'd1) begin
                    state_next = ST_LEN;
                end else begin
                    ret_next = ST_LEN;
                end
            end
            ST_LEN: begin
                cmd.put_byte  = 1'b1;
                cmd.put_value = status.len_byte;
                lcnt_next     = lcnt_reg + 3'd1;
                if (lcnt_reg == 3'd7) begin
                    cmd.load_vars = 1'b1;
                    ret_next      = ST_OUT;
                    state_next    = ST_ROUND;
                end
            end
            ST_ROUND: begin
                cmd.do_round = 1'b1;
                if (status.round == 6'd63) begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                cmd.add_hash = 1'b1;
                idx_next     = '0;
                unique case (ret_reg)
                    ST_PAD:  state_next = ST_PAD;
                    ST_OUT:  state_next = ST_OUT;
                    default: state_next = ST_IDLE;
                endcase
                if (ret_reg == ST_LEN) begin
                    state_next = ST_PAD;
                end
            end
            ST_OUT: begin
                out_valid = 1'b1;
                if (out_fire) begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7) begin
                        cmd.restart = 1'b1;
                        state_next  = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign out_index = idx_reg;

    property p_out_only_in_out;
        @(posedge aclk) disable iff (!aresetn) out_valid |-> state_reg == ST_OUT;
    endproperty
    a_out_only_in_out: assert property (p_out_only_in_out) else $error("output outside ST_OUT");

    property p_round_enters_at_zero;
        @(posedge aclk) disable iff (!aresetn)
            (state_reg != ST_ROUND && state_next == ST_ROUND) |=> status.round == 6'd0;
    endproperty
    a_round_enters_at_zero: assert property (p_round_enters_at_zero)
        else $error("round counter not zero at block start");

    property p_no_accept_busy;
        @(posedge aclk) disable iff (!aresetn) in_ready |-> state_reg == ST_IDLE;
    endproperty
    a_no_accept_busy: assert property (p_no_accept_busy) else $error("accept while busy");

endmodule

// ===== design/sha256_datapath.sv =====
// ----------------------------------------------------------------------------
// SHA-256 datapath
// Block buffer, rolling schedule, working variables, running hash and length.
// ----------------------------------------------------------------------------
module sha256_datapath (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  sha256_pkg::ctrl_cmd_t     cmd,
    input  logic [2:0]                out_index,
    output sha256_pkg::ctrl_status_t  status,
    output logic [31:0]               digest_word
);
    import sha256_pkg::*;

    logic [31:0] hash_reg [8];
    logic [31:0] var_reg [8];
    logic [31:0] sched_reg [16];
    logic [63:0] bits_reg;
    logic [5:0]  pos_reg;
    logic [5:0]  round_reg;
    logic [63:0] len_reg;

    logic [31:0] w_cur, a15, a2, ws0, ws1, ws_new;
    logic [31:0] e_s1, ch, t1, a_s0, mj, t2;
    logic [3:0]  widx;
    logic [1:0]  bsel;

    assign widx = pos_reg[5:2];
    assign bsel = pos_reg[1:0];

    always_comb begin
        a15    = sched_reg[round_reg[3:0] + 4'd1];
        a2     = sched_reg[round_reg[3:0] + 4'd14];
        ws0    = rotr(a15, 7) ^ rotr(a15, 18) ^ (a15 >> 3);
        ws1    = rotr(a2, 17) ^ rotr(a2, 19) ^ (a2 >> 10);
        ws_new = sched_reg[round_reg[3:0]] + ws0 + sched_reg[round_reg[3:0] + 4'd9] + ws1;
        w_cur  = round_reg[5:4] == 2'd0 ? sched_reg[round_reg[3:0]] : ws_new;
        e_s1   = rotr(var_reg[4], 6) ^ rotr(var_reg[4], 11) ^ rotr(var_reg[4], 25);
        ch     = (var_reg[4] & var_reg[5]) ^ (~var_reg[4] & var_reg[6]);
        t1     = var_reg[7] + e_s1 + ch + ROUND_K[round_reg] + w_cur;
        a_s0   = rotr(var_reg[0], 2) ^ rotr(var_reg[0], 13) ^ rotr(var_reg[0], 22);
        mj     = (var_reg[0] & var_reg[1]) ^ (var_reg[0] & var_reg[2])
               ^ (var_reg[1] & var_reg[2]);
        t2     = a_s0 + mj;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            round_reg <= '0;
            bits_reg  <= '0;
            for (int i = 0; i < 8; i++) begin
                hash_reg[i] <= INIT_HASH[i];
            end
        end else begin
            if (cmd.put_byte) begin
                pos_reg <= pos_reg + 6'd1;
            end
            if (cmd.add_bits) begin
                bits_reg <= bits_reg + 64'd8;
            end
            if (cmd.do_round) begin
                round_reg <= round_reg + 6'd1;
            end
            if (cmd.add_hash) begin
                for (int i = 0; i < 8; i++) begin
                    hash_reg[i] <= hash_reg[i] + var_reg[i];
                end
            end
            if (cmd.restart) begin
                bits_reg <= '0;
                pos_reg  <= '0;
                for (int i = 0; i < 8; i++) begin
                    hash_reg[i] <= INIT_HASH[i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.put_byte) begin
            unique case (bsel)
                2'd0: sched_reg[widx][31:24] <= cmd.put_value;
                2'd1: sched_reg[widx][23:16] <= cmd.put_value;
                2'd2: sched_reg[widx][15:8]  <= cmd.put_value;
                2'd3: sched_reg[widx][7:0]   <= cmd.put_value;
                default: ;
            endcase
        end
        if (cmd.do_round && round_reg[5:4] != 2'd0) begin
            sched_reg[round_reg[3:0]] <= ws_new;
        end
        if (cmd.put_byte && pos_reg == LEN_POS) begin
            len_reg <= {bits_reg[55:0], 8'h00};
        end else if (cmd.put_byte && pos_reg > LEN_POS) begin
            len_reg <= {len_reg[55:0], 8'h00};
        end
        if (cmd.load_vars) begin
            for (int i = 0; i < 8; i++) begin
                var_reg[i] <= hash_reg[i];
            end
        end else if (cmd.do_round) begin
            var_reg[7] <= var_reg[6];
            var_reg[6] <= var_reg[5];
            var_reg[5] <= var_reg[4];
            var_reg[4] <= var_reg[3] + t1;
            var_reg[3] <= var_reg[2];
            var_reg[2] <= var_reg[1];
            var_reg[1] <= var_reg[0];
            var_reg[0] <= t1 + t2;
        end
    end

    assign status.byte_pos = pos_reg;
    assign status.round    = round_reg;
    assign status.len_byte = (pos_reg == LEN_POS) ? bits_reg[63:56] : len_reg[63:56];
    assign digest_word     = hash_reg[out_index];

endmodule

// ===== design/sha256_message_digest.sv =====
// ----------------------------------------------------------------------------
// SHA-256 message digest
// Byte-stream SHA-256 hasher with a controller and a shared round datapath.
// ----------------------------------------------------------------------------
// Data bytes are accepted while idle; the byte that completes a 64-byte block
// adds the 64 rounds, one per cycle, and the hash update.
// The final beat adds padding, 8 length bytes, one or two compressions, then
// eight digest words, one per cycle while m_tready is high.
// Reset is synchronous, active low; the hash returns to its initial value.
module sha256_message_digest (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // byte_valid
    input  logic        s_tlast,   // end_of_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index
    output logic        m_tlast    // last_word
);
    import sha256_pkg::*;

    ctrl_cmd_t    cmd;
    ctrl_status_t status;
    logic [2:0]   out_index;
    logic [31:0]  digest_word;

    sha256_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_fire       (s_tvalid && s_tready),
        .in_byte       (s_tdata),
        .in_valid_byte (s_tuser),
        .in_end        (s_tlast),
        .in_ready      (s_tready),
        .out_fire      (m_tvalid && m_tready),
        .out_valid     (m_tvalid),
        .out_index     (out_index),
        .status        (status),
        .cmd           (cmd)
    );

    sha256_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .out_index   (out_index),
        .status      (status),
        .digest_word (digest_word)
    );

    assign m_tdata = {5'd0, out_index, digest_word};
    assign m_tlast = (out_index == 3'd7);

endmodule
